/* design/apc_pkg.sv */
// Package: widths, reset values, register indexes and controller/datapath interface types.
`timescale 1ns / 1ps
package apc_pkg;

  localparam int NUM_WIDTH = 16;
  localparam int OPW       = (NUM_WIDTH > 16) ? NUM_WIDTH : 16;
  localparam int SUMW      = OPW + 3;
  localparam int CNT_W     = $clog2(OPW);
  localparam int CFG_W     = 16;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 18;
  localparam int IDX_W     = 1;

  localparam logic [CFG_W-1:0] LOWER_RESET = 16'd1000;
  localparam logic [CFG_W-1:0] UPPER_RESET = 16'hFFFF;
  localparam logic [OPW-1:0]   NUM_MASK    = {OPW{1'b1}} >> (OPW - NUM_WIDTH);

  typedef enum logic [IDX_W-1:0] {
    REG_LOWER = 1'b0,
    REG_UPPER = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic begin1;
    logic begin2;
    logic step;
    logic accum;
    logic emit1;
    logic emit2;
  } apc_cmd_t;

  typedef struct packed {
    logic div_last;
    logic stop;
    logic eligible;
  } apc_stat_t;

endpackage

/* design/apc_ctrl.sv */
// Controller: sequences the two divisor-sum passes and the result strobe.
`timescale 1ns / 1ps
module apc_ctrl
  import apc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  apc_stat_t stat_i,
  output apc_cmd_t  cmd_o,
  output logic      done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV1,
    S_CHK1,
    S_DIV2,
    S_CHK2
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.begin1 = 1'b1;
          state_d      = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd_o.step = 1'b1;
        if (stat_i.div_last) state_d = S_CHK1;
      end
      S_CHK1: begin
        if (stat_i.stop) begin
          if (stat_i.eligible) begin
            cmd_o.begin2 = 1'b1;
            state_d      = S_DIV2;
          end else begin
            cmd_o.emit1 = 1'b1;
            done_d      = 1'b1;
            state_d     = S_IDLE;
          end
        end else begin
          cmd_o.accum = 1'b1;
          state_d     = S_DIV1;
        end
      end
      S_DIV2: begin
        cmd_o.step = 1'b1;
        if (stat_i.div_last) state_d = S_CHK2;
      end
      S_CHK2: begin
        if (stat_i.stop) begin
          cmd_o.emit2 = 1'b1;
          done_d      = 1'b1;
          state_d     = S_IDLE;
        end else begin
          cmd_o.accum = 1'b1;
          state_d     = S_DIV2;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

/* design/apc_dp.sv */
// Datapath: bound registers, trial divisor, restoring divider, sum accumulator, result registers.
`timescale 1ns / 1ps
module apc_dp
  import apc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic [IN_W-1:0]  candidate_i,
  input  apc_cmd_t         cmd_i,
  output apc_stat_t        stat_o,
  output logic [OUT_W-1:0] divisor_sum_o,
  output logic             is_pair_o,
  output logic             is_perfect_o
);

  logic [CFG_W-1:0] lower_q, upper_q;
  logic [OPW-1:0]   n_q, op_q, d_q, quo_q, rem_q;
  logic [SUMW-1:0]  b_q, tot_q;
  logic [CNT_W-1:0] cnt_q;
  logic [OUT_W-1:0] sum_q;
  logic             pair_q, perf_q;

  logic [OPW-1:0]  cand_n;
  logic [SUMW-1:0] ali, n_ext, lower_ext, upper_ext;
  logic [OPW:0]    trial;
  logic            trial_ge;
  logic            pair2;

  assign cand_n    = OPW'(candidate_i) & NUM_MASK;
  assign ali       = tot_q - SUMW'(op_q);
  assign n_ext     = SUMW'(n_q);
  assign lower_ext = SUMW'(lower_q);
  assign upper_ext = SUMW'(upper_q);
  assign trial     = {rem_q, quo_q[OPW-1]};
  assign trial_ge  = (trial >= {1'b0, d_q});
  assign pair2     = (ali == n_ext);

  assign stat_o.div_last = (cnt_q == CNT_W'(OPW - 1));
  assign stat_o.stop     = (quo_q < d_q);
  assign stat_o.eligible = (n_q != '0) && (n_ext >= lower_ext) && (n_ext <= upper_ext) &&
                           (ali >= n_ext) && (ali <= upper_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LOWER_RESET;
      upper_q <= UPPER_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_LOWER: lower_q <= cfg_wdata_i;
        REG_UPPER: upper_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.begin1) begin
      n_q   <= cand_n;
      op_q  <= cand_n;
      quo_q <= cand_n;
      rem_q <= '0;
      cnt_q <= '0;
      d_q   <= OPW'(1);
      tot_q <= '0;
    end
    if (cmd_i.begin2) begin
      b_q   <= ali;
      op_q  <= ali[OPW-1:0];
      quo_q <= ali[OPW-1:0];
      rem_q <= '0;
      cnt_q <= '0;
      d_q   <= OPW'(1);
      tot_q <= '0;
    end
    if (cmd_i.step) begin
      if (trial_ge) begin
        rem_q <= OPW'(trial - {1'b0, d_q});
        quo_q <= {quo_q[OPW-2:0], 1'b1};
      end else begin
        rem_q <= trial[OPW-1:0];
        quo_q <= {quo_q[OPW-2:0], 1'b0};
      end
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.accum) begin
      if (rem_q == '0) begin
        tot_q <= tot_q + SUMW'(d_q) + ((quo_q != d_q) ? SUMW'(quo_q) : '0);
      end
      d_q   <= d_q + OPW'(1);
      quo_q <= op_q;
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.emit1) begin
      sum_q  <= ali[OUT_W-1:0];
      pair_q <= 1'b0;
      perf_q <= 1'b0;
    end
    if (cmd_i.emit2) begin
      sum_q  <= b_q[OUT_W-1:0];
      pair_q <= pair2;
      perf_q <= pair2 && (b_q == n_ext);
    end
  end

  assign divisor_sum_o = sum_q;
  assign is_pair_o     = pair_q;
  assign is_perfect_o  = perf_q;

endmodule

/* design/amicable_pair_checker.sv */
// Top level: aliquot sum and amicable/perfect pair test of one candidate per command.
//
//   channel  | ports                                   | transfer
//   ---------+-----------------------------------------+----------------------------
//   command  | start, busy, candidate_i                | start high while busy low
//   result   | done_o, divisor_sum_o, is_pair_o,       | done_o high, one cycle
//            | is_perfect_o                            |
//   config   | cfg_we_i, cfg_idx_i, cfg_wdata_i        | cfg_we_i high
//
// One divisor sum over operand m tries the divisors 1 to floor(sqrt(m)) + 1: each trial
// divisor runs OPW steps of the shared restoring divider plus one check state.
// An item runs one divisor sum on n, and a second one on the sum b when the pair test runs.
// Reset sets lower_bound to 1000 and upper_bound to 65535; no clearing pass.
// Results are shown for one cycle; the receiver cannot stall, and a new command is
// accepted in the cycle the result is shown.
`timescale 1ns / 1ps
module amicable_pair_checker
  import apc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [IN_W-1:0]  candidate_i,
  output logic             done_o,
  output logic [OUT_W-1:0] divisor_sum_o,
  output logic             is_pair_o,
  output logic             is_perfect_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  apc_cmd_t  cmd;
  apc_stat_t stat;

  apc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd),
    .done_o (done_o)
  );

  apc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .candidate_i   (candidate_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .divisor_sum_o (divisor_sum_o),
    .is_pair_o     (is_pair_o),
    .is_perfect_o  (is_perfect_o)
  );

endmodule

/* tb/apc_checker.sv */
// Checker: watches the command, result and config channels, predicts each result and compares.
`timescale 1ns / 1ps
module apc_checker
  import apc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [IN_W-1:0]  candidate_i,
  input  logic             done_i,
  input  logic [OUT_W-1:0] divisor_sum_i,
  input  logic             is_pair_i,
  input  logic             is_perfect_i,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output int               pending_o,
  output int               fail_count_o
);

  typedef struct packed {
    logic [IN_W-1:0]  cand;
    logic [OUT_W-1:0] sum;
    logic             pair;
    logic             perfect;
  } pair_verdict_t;

  pair_verdict_t    verdicts_q [$];
  logic [CFG_W-1:0] lower_bound;
  logic [CFG_W-1:0] upper_bound;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic longint unsigned aliquot_sum(input longint unsigned n);
    longint unsigned d;
    longint unsigned total;
    total = 0;
    if (n == 0) return 0;
    for (d = 1; d * d <= n; d++) begin
      if (n % d == 0) begin
        total += d;
        if (n / d != d) total += n / d;
      end
    end
    return total - n;
  endfunction

  function automatic pair_verdict_t predict_verdict(input logic [IN_W-1:0] cand);
    longint unsigned n;
    longint unsigned b;
    pair_verdict_t   v;
    n         = cand & NUM_MASK;
    b         = aliquot_sum(n);
    v.cand    = cand;
    v.sum     = b[OUT_W-1:0];
    v.pair    = 1'b0;
    if (n != 0 && n >= lower_bound && n <= upper_bound && b >= n && b <= upper_bound)
      v.pair = (aliquot_sum(b) == n);
    v.perfect = v.pair && (b == n);
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0d ns: mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pair_verdict_t want;
    if (!rst_ni) begin
      lower_bound = LOWER_RESET;
      upper_bound = UPPER_RESET;
      verdicts_q.delete();
    end else begin
      if (done_i) begin
        if (verdicts_q.size() == 0) begin
          report_mismatch($sformatf("result transfer with none outstanding, sum %0d",
                                    divisor_sum_i));
        end else begin
          want = verdicts_q.pop_front();
          if (divisor_sum_i !== want.sum)
            report_mismatch($sformatf("candidate %0d divisor_sum %0d, want %0d",
                                      want.cand, divisor_sum_i, want.sum));
          if (is_pair_i !== want.pair)
            report_mismatch($sformatf("candidate %0d is_pair %b, want %b",
                                      want.cand, is_pair_i, want.pair));
          if (is_perfect_i !== want.perfect)
            report_mismatch($sformatf("candidate %0d is_perfect %b, want %b",
                                      want.cand, is_perfect_i, want.perfect));
        end
      end
      if (start_i && !busy_i) verdicts_q.push_back(predict_verdict(candidate_i));
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_LOWER: lower_bound = cfg_wdata_i;
          REG_UPPER: upper_bound = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    pending_o = verdicts_q.size();
  end

endmodule

/* tb/tb_top.sv */
// Testbench top: clock, reset, bound settings and candidate stimulus, final verdict.
`timescale 1ns / 1ps
module tb_top;
  import apc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  logic [IN_W-1:0]  candidate_i = '0;
  logic             done_o;
  logic [OUT_W-1:0] divisor_sum_o;
  logic             is_pair_o;
  logic             is_perfect_o;
  logic             cfg_we_i    = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  int               pending;
  int               fail_count;
  int               sender_idle_pct = 0;
  int unsigned      cycle_count = 0;
  logic [CFG_W-1:0] lo;
  logic [CFG_W-1:0] hi;

  logic [IN_W-1:0] corner_candidates [$] = '{
    16'd0, 16'd1, 16'd2, 16'd6, 16'd28, 16'd496, 16'd8128, 16'd220, 16'd284,
    16'd1184, 16'd1210, 16'd2620, 16'd2924, 16'd12285, 16'd14595, 16'd17296,
    16'd18416, 16'd63020, 16'd65535, 16'd32768, 16'd55440, 16'd65521
  };

  logic [IN_W-1:0] notable_candidates [$] = '{
    16'd6, 16'd28, 16'd496, 16'd8128, 16'd220, 16'd284, 16'd1184, 16'd1210,
    16'd2620, 16'd2924, 16'd5020, 16'd5564, 16'd6232, 16'd6368, 16'd10744,
    16'd10856, 16'd12285, 16'd14595, 16'd17296, 16'd18416, 16'd63020
  };

  always #5 clk_i = ~clk_i;

  amicable_pair_checker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .candidate_i   (candidate_i),
    .done_o        (done_o),
    .divisor_sum_o (divisor_sum_o),
    .is_pair_o     (is_pair_o),
    .is_perfect_o  (is_perfect_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  apc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .candidate_i   (candidate_i),
    .done_i        (done_o),
    .divisor_sum_i (divisor_sum_o),
    .is_pair_i     (is_pair_o),
    .is_perfect_i  (is_perfect_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_candidate(input logic [IN_W-1:0] n);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(9, 600)) @(posedge clk_i);
      else repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start       <= 1'b1;
    candidate_i <= n;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Hold off until every outstanding result has been transferred.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic set_bounds(input logic [CFG_W-1:0] lower, input logic [CFG_W-1:0] upper);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_LOWER;
    cfg_wdata_i <= lower;
    @(posedge clk_i);
    cfg_idx_i   <= REG_UPPER;
    cfg_wdata_i <= upper;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [IN_W-1:0] random_candidate();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return notable_candidates[$urandom_range(0, notable_candidates.size() - 1)];
    if (pick < 85) return IN_W'($urandom_range(0, 2047));
    return IN_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 34;
    foreach (corner_candidates[i]) send_candidate(corner_candidates[i]);

    set_bounds(16'd0, 16'hFFFF);
    repeat (25) send_candidate(random_candidate());

    // Lower bound above upper bound: no pair can be reported.
    sender_idle_pct = 52;
    set_bounds(16'hFFFF, 16'd0);
    repeat (25) send_candidate(random_candidate());

    lo = CFG_W'($urandom_range(0, 12000));
    hi = CFG_W'($urandom_range(lo, 65535));
    set_bounds(lo, hi);
    repeat (25) send_candidate(random_candidate());

    sender_idle_pct = 0;
    set_bounds(16'd220, 16'd1210);
    repeat (25) send_candidate(random_candidate());

    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
